// ----- hw/rtl/cab_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cab_pkg
// Shared types, register indexes and divide-by-255 helpers for the coverage
// alpha blend core.
// ----------------------------------------------------------------------------
package cab_pkg;

    localparam int CfgIndexWidth = 4;
    localparam int ChanWidth     = 8;
    localparam int NumColor      = 3;

    localparam logic [CfgIndexWidth-1:0] CFG_BRUSH_RED   = 4'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_BRUSH_GREEN = 4'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_BRUSH_BLUE  = 4'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_BRUSH_ALPHA = 4'd3;

    localparam logic [7:0] CH_MAX     = 8'd255;
    localparam logic [7:0] ROUND_HALF = 8'd127;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_BRUSH,
        MODE_BLEND
    } t_mode;

    // Pixel and flags that travel alongside the divider.
    typedef struct packed {
        logic       blend;
        logic       written;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_side;

    // First guess of x / 255 as x * 257 / 65536. It never overshoots and
    // falls short by at most one for any x below 255 * 65536.
    function automatic logic [15:0] div255_est(input logic [23:0] x);
        logic [32:0] m;
        m = {9'b0, x} + {1'b0, x, 8'b0};
        return m[31:16];
    endfunction

    // Corrects the guess from the remainder x - q * 255.
    function automatic logic [15:0] div255_fix(input logic [23:0] x,
                                               input logic [15:0] q);
        logic [23:0] p;
        logic [23:0] diff;
        logic [9:0]  r;
        p    = {q, 8'b0} - {8'b0, q};
        diff = x - p;
        r    = diff[9:0];
        if (r >= 10'd510) begin
            return q + 16'd2;
        end else if (r >= 10'd255) begin
            return q + 16'd1;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cab_div_pipe.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cab_div_pipe
// Restoring divider of three color sums by the output alpha, one quotient bit
// per stage, with saturation at 255 and the final output select.
// ----------------------------------------------------------------------------
module cab_div_pipe import cab_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [16:0] i_sum [0:NumColor-1],
    input  wire logic [7:0]  i_oa,
    input  wire t_side       i_side,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic             o_written
);

    // Stage 0 checks saturation, stages 1 to 8 produce quotient bits 7 to 0,
    // stage 9 is the output register.
    localparam int NumStage = 10;
    localparam int LastBit  = 8;

    logic [NumStage-1:0] r_v;
    logic [NumStage-1:0] en;

    logic [15:0] r_rem [0:LastBit][0:NumColor-1];
    logic [7:0]  r_q   [0:LastBit][0:NumColor-1];
    logic        r_sat [0:LastBit][0:NumColor-1];
    logic [7:0]  r_oa  [0:LastBit];
    t_side       r_side[0:LastBit];

    logic [15:0] n_rem [1:LastBit][0:NumColor-1];
    logic [7:0]  n_q   [1:LastBit][0:NumColor-1];

    logic [7:0]  r_out_red;
    logic [7:0]  r_out_green;
    logic [7:0]  r_out_blue;
    logic [7:0]  r_out_alpha;
    logic        r_out_written;

    logic [7:0]  n_out_chan [0:NumColor-1];

    always_comb begin
        en[NumStage-1] = !r_v[NumStage-1] || !i_stall;
        for (int j = NumStage - 2; j >= 0; j--) begin
            en[j] = !r_v[j] || en[j+1];
        end
    end

    assign o_stall = !en[0];

    always_comb begin
        logic [15:0] dvs;
        logic        ge;
        for (int j = 1; j <= LastBit; j++) begin
            dvs = {r_oa[j-1], 8'b0} >> j;
            for (int c = 0; c < NumColor; c++) begin
                ge            = r_rem[j-1][c] >= dvs;
                n_rem[j][c]   = ge ? (r_rem[j-1][c] - dvs) : r_rem[j-1][c];
                n_q[j][c]     = r_q[j-1][c];
                n_q[j][c][LastBit-j] = ge;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NumColor; c++) begin
            n_out_chan[c] = r_sat[LastBit][c] ? CH_MAX : r_q[LastBit][c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < NumStage; j++) begin
                if (en[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int c = 0; c < NumColor; c++) begin
                r_sat[0][c] <= i_sum[c] >= {1'b0, i_oa, 8'b0};
                r_rem[0][c] <= i_sum[c][15:0];
                r_q[0][c]   <= '0;
            end
            r_oa[0]   <= i_oa;
            r_side[0] <= i_side;
        end
        for (int j = 1; j <= LastBit; j++) begin
            if (en[j]) begin
                for (int c = 0; c < NumColor; c++) begin
                    r_sat[j][c] <= r_sat[j-1][c];
                    r_rem[j][c] <= n_rem[j][c];
                    r_q[j][c]   <= n_q[j][c];
                end
                r_oa[j]   <= r_oa[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
        if (en[NumStage-1]) begin
            if (r_side[LastBit].blend) begin
                r_out_red   <= n_out_chan[0];
                r_out_green <= n_out_chan[1];
                r_out_blue  <= n_out_chan[2];
            end else begin
                r_out_red   <= r_side[LastBit].red;
                r_out_green <= r_side[LastBit].green;
                r_out_blue  <= r_side[LastBit].blue;
            end
            r_out_alpha   <= r_side[LastBit].alpha;
            r_out_written <= r_side[LastBit].written;
        end
    end

    assign o_valid   = r_v[NumStage-1];
    assign o_red     = r_out_red;
    assign o_green   = r_out_green;
    assign o_blue    = r_out_blue;
    assign o_alpha   = r_out_alpha;
    assign o_written = r_out_written;

endmodule
`default_nettype wire

// ----- hw/rtl/coverage_alpha_blend_core.sv -----
`default_nettype none
// 6 blend stages, then 10 stages of the bit-per-stage output-alpha divider.
// Throughput: one pixel per cycle; a stall only holds stages that are full.
// Reset clears all valid bits and sets the brush color to 0, 0, 0, 255.
// ----------------------------------------------------------------------------
// coverage_alpha_blend_core
// Source-over compositing of a configured brush color onto RGBA8 pixels,
// with the source alpha scaled by per-pixel coverage.
// ----------------------------------------------------------------------------
module coverage_alpha_blend_core import cab_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CfgIndexWidth-1:0] i_cfg_index,
    input  wire logic [7:0]               i_cfg_data,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [7:0]               i_dst_red,
    input  wire logic [7:0]               i_dst_green,
    input  wire logic [7:0]               i_dst_blue,
    input  wire logic [7:0]               i_dst_alpha,
    input  wire logic [7:0]               i_coverage,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [7:0]                    o_out_red,
    output logic [7:0]                    o_out_green,
    output logic [7:0]                    o_out_blue,
    output logic [7:0]                    o_out_alpha,
    output logic                          o_written
);

    localparam int NumChan = NumColor + 1;
    localparam int AIdx    = NumColor;

    logic [7:0] r_brush_red;
    logic [7:0] r_brush_green;
    logic [7:0] r_brush_blue;
    logic [7:0] r_brush_alpha;
    logic [7:0] w_brush [0:NumColor-1];

    logic en1, en2, en3, en4, en5, en6;
    logic div_stall;

    // Stage 1: brush alpha times coverage.
    logic        r1_v;
    logic [15:0] r1_prod;
    logic        r1_cov_zero;
    logic        r1_cov_full;
    logic [7:0]  r1_d [0:NumChan-1];

    // Stage 2: scaled source alpha and case select.
    logic        r2_v;
    logic [7:0]  r2_sa;
    t_mode       r2_mode;
    logic [7:0]  r2_d [0:NumChan-1];
    logic [15:0] w2_sa;
    logic [7:0]  n2_sa;
    t_mode       n2_mode;

    // Stage 3: first products.
    logic        r3_v;
    logic [15:0] r3_dai;
    logic [15:0] r3_ssa [0:NumColor-1];
    logic [7:0]  r3_sa;
    t_mode       r3_mode;
    logic [7:0]  r3_d [0:NumChan-1];

    // Stage 4: dividends for the rounded divide by 255.
    logic        r4_v;
    logic [23:0] r4_x [0:NumChan-1];
    logic [15:0] r4_ssa [0:NumColor-1];
    logic [7:0]  r4_sa;
    t_mode       r4_mode;
    logic [7:0]  r4_d [0:NumChan-1];

    // Stage 5: quotient guesses.
    logic        r5_v;
    logic [23:0] r5_x [0:NumChan-1];
    logic [15:0] r5_q1 [0:NumChan-1];
    logic [15:0] r5_ssa [0:NumColor-1];
    logic [7:0]  r5_sa;
    t_mode       r5_mode;
    logic [7:0]  r5_d [0:NumChan-1];

    // Stage 6: premultiplied sums and output alpha.
    logic        r6_v;
    logic [16:0] r6_sum [0:NumColor-1];
    logic [7:0]  r6_oa;
    t_mode       r6_mode;
    logic [7:0]  r6_d [0:NumChan-1];
    logic [15:0] w6_q [0:NumChan-1];
    logic [9:0]  w6_oa;

    t_side       w_side;

    assign w_brush[0] = r_brush_red;
    assign w_brush[1] = r_brush_green;
    assign w_brush[2] = r_brush_blue;

    // Configuration port.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brush_red   <= '0;
            r_brush_green <= '0;
            r_brush_blue  <= '0;
            r_brush_alpha <= CH_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BRUSH_RED:   r_brush_red   <= i_cfg_data;
                CFG_BRUSH_GREEN: r_brush_green <= i_cfg_data;
                CFG_BRUSH_BLUE:  r_brush_blue  <= i_cfg_data;
                CFG_BRUSH_ALPHA: r_brush_alpha <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage takes new data when it is empty or its successor moves.
    always_comb begin
        en6 = !r6_v || !div_stall;
        en5 = !r5_v || en6;
        en4 = !r4_v || en5;
        en3 = !r3_v || en4;
        en2 = !r2_v || en3;
        en1 = !r1_v || en2;
    end

    assign o_stall = !en1;

    always_comb begin
        w2_sa = div255_fix({8'b0, r1_prod}, div255_est({8'b0, r1_prod}));
        n2_sa = r1_cov_full ? CH_MAX : w2_sa[7:0];
        if (r1_cov_zero || n2_sa == 8'd0) begin
            n2_mode = MODE_PASS;
        end else if (n2_sa == CH_MAX) begin
            n2_mode = MODE_BRUSH;
        end else begin
            n2_mode = MODE_BLEND;
        end
    end

    always_comb begin
        for (int c = 0; c < NumChan; c++) begin
            w6_q[c] = div255_fix(r5_x[c], r5_q1[c]);
        end
        w6_oa = {2'b0, r5_sa} + w6_q[AIdx][9:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
            if (en6) r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_prod     <= 16'(r_brush_alpha) * 16'(i_coverage) + 16'(ROUND_HALF);
            r1_cov_zero <= i_coverage == 8'd0;
            r1_cov_full <= i_coverage == CH_MAX;
            r1_d[0]     <= i_dst_red;
            r1_d[1]     <= i_dst_green;
            r1_d[2]     <= i_dst_blue;
            r1_d[AIdx]  <= i_dst_alpha;
        end
        if (en2) begin
            r2_sa   <= n2_sa;
            r2_mode <= n2_mode;
            r2_d    <= r1_d;
        end
        if (en3) begin
            r3_dai <= 16'(r2_d[AIdx]) * 16'(CH_MAX - r2_sa);
            for (int c = 0; c < NumColor; c++) begin
                r3_ssa[c] <= 16'(w_brush[c]) * 16'(r2_sa);
            end
            r3_sa   <= r2_sa;
            r3_mode <= r2_mode;
            r3_d    <= r2_d;
        end
        if (en4) begin
            for (int c = 0; c < NumColor; c++) begin
                r4_x[c] <= 24'(r3_d[c]) * 24'(r3_dai) + 24'(ROUND_HALF);
            end
            r4_x[AIdx] <= {8'b0, r3_dai} + 24'(ROUND_HALF);
            r4_ssa     <= r3_ssa;
            r4_sa      <= r3_sa;
            r4_mode    <= r3_mode;
            r4_d       <= r3_d;
        end
        if (en5) begin
            for (int c = 0; c < NumChan; c++) begin
                r5_q1[c] <= div255_est(r4_x[c]);
            end
            r5_x    <= r4_x;
            r5_ssa  <= r4_ssa;
            r5_sa   <= r4_sa;
            r5_mode <= r4_mode;
            r5_d    <= r4_d;
        end
        if (en6) begin
            for (int c = 0; c < NumColor; c++) begin
                r6_sum[c] <= {1'b0, r5_ssa[c]} + {1'b0, w6_q[c]};
            end
            r6_oa   <= (w6_oa > 10'(CH_MAX)) ? CH_MAX : w6_oa[7:0];
            r6_mode <= r5_mode;
            r6_d    <= r5_d;
        end
    end

    always_comb begin
        unique case (r6_mode)
            MODE_BRUSH: begin
                w_side.blend   = 1'b0;
                w_side.written = 1'b1;
                w_side.red     = r_brush_red;
                w_side.green   = r_brush_green;
                w_side.blue    = r_brush_blue;
                w_side.alpha   = r_brush_alpha;
            end
            MODE_BLEND: begin
                w_side.blend   = 1'b1;
                w_side.written = 1'b1;
                w_side.red     = r6_d[0];
                w_side.green   = r6_d[1];
                w_side.blue    = r6_d[2];
                w_side.alpha   = r6_oa;
            end
            default: begin
                w_side.blend   = 1'b0;
                w_side.written = 1'b0;
                w_side.red     = r6_d[0];
                w_side.green   = r6_d[1];
                w_side.blue    = r6_d[2];
                w_side.alpha   = r6_d[AIdx];
            end
        endcase
    end

    cab_div_pipe u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r6_v),
        .o_stall   (div_stall),
        .i_sum     (r6_sum),
        .i_oa      (r6_oa),
        .i_side    (w_side),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_red     (o_out_red),
        .o_green   (o_out_green),
        .o_blue    (o_out_blue),
        .o_alpha   (o_out_alpha),
        .o_written (o_written)
    );

endmodule
`default_nettype wire
